// ===== rtl/core/i2cmw_pkg.sv =====
package i2cmw_pkg;

	localparam int RECOVERY_PULSES_DEF = 9;
	localparam int BITS_PER_FRAME      = 8;
	localparam int HALF_W              = 10;
	localparam int STRETCH_W           = 16;
	localparam int CFG_DATA_W          = 16;
	localparam int IN_TDATA_W          = 16;
	localparam int OUT_TDATA_W         = 8;

	localparam logic [HALF_W-1:0]    HALF_RESET    = 10'd5;
	localparam logic [STRETCH_W-1:0] STRETCH_RESET = 16'd100;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_WRITE   = 3'd2,
		ACT_STOP    = 3'd3,
		ACT_RECOVER = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NACK    = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_BUSY    = 3'd3,
		ST_SKIPPED = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_HALF_PERIOD = 1'b0,
		REG_STRETCH_TO  = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		PH_IDLE, PH_S_CHECK, PH_S_LOW, PH_S_END,
		PH_W_BIT, PH_W_CLK, PH_W_LOW, PH_W_ACK_REL, PH_W_ACK_CLK,
		PH_W_ACK_SAMPLE, PH_W_END,
		PH_P_CLK, PH_P_SDA, PH_P_END,
		PH_R_CLK, PH_R_NEXT
	} phase_t;

	// one tick as held in the queue
	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
		logic       scl_sense;
		logic       sda_sense;
	} tick_t;

endpackage

// ===== rtl/core/i2cmw_front.sv =====
module i2cmw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [i2cmw_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                q_valid,
	output i2cmw_pkg::tick_t                    q_tick,
	input  logic                                q_pop
);
	import i2cmw_pkg::*;

	tick_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	tick_t       in_tick;
	logic        push;
	logic        pop;
	logic [2:0]  raw_action;

	// classify the command; unknown codes become no command
	always_comb begin
		raw_action = s_tdata[2:0];
		unique case (raw_action)
			ACT_START, ACT_WRITE, ACT_STOP, ACT_RECOVER: in_tick.action = action_t'(raw_action);
			default: in_tick.action = ACT_NONE;
		endcase
		in_tick.data_byte = s_tdata[10:3];
		in_tick.scl_sense = s_tdata[11];
		in_tick.sda_sense = s_tdata[12];
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_tick   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== rtl/core/i2cmw_engine.sv =====
module i2cmw_engine #(
	parameter int RECOVERY_PULSES = i2cmw_pkg::RECOVERY_PULSES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [i2cmw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                q_valid,
	input  i2cmw_pkg::tick_t                    q_tick,
	output logic                                q_pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [i2cmw_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import i2cmw_pkg::*;

	localparam logic [3:0] PULSES  = 4'(RECOVERY_PULSES);
	localparam logic [3:0] FRAME_N = 4'(BITS_PER_FRAME);

	logic [HALF_W-1:0]    half_q;
	logic [STRETCH_W-1:0] timeout_q;

	phase_t               phase_q, n_phase, act_ph;
	logic [3:0]           bit_q, n_bit;
	logic [7:0]           shift_q, n_shift;
	logic [HALF_W-1:0]    delay_q, n_delay, delay_dec;
	logic [STRETCH_W-1:0] stretch_q, n_stretch, stretch_inc;
	logic [3:0]           pulse_q, n_pulse;
	status_t              err_q, n_err, code;
	logic                 scl_q, n_scl;
	logic                 sda_q, n_sda;
	logic                 wait_q, n_wait;
	logic                 do_act;
	logic                 done;
	status_t              stat;

	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                 step;

	assign step     = q_valid && (!out_valid_q || m_tready);
	assign q_pop    = step;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= HALF_RESET;
			timeout_q <= STRETCH_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_HALF_PERIOD: half_q    <= cfg_data[HALF_W-1:0];
				REG_STRETCH_TO:  timeout_q <= cfg_data[STRETCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_phase   = phase_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_delay   = delay_q;
		n_stretch = stretch_q;
		n_pulse   = pulse_q;
		n_err     = err_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_wait    = wait_q;
		do_act    = 1'b0;
		act_ph    = phase_q;
		done      = 1'b0;
		stat      = ST_OK;
		code      = ST_OK;
		delay_dec   = delay_q - 10'd1;
		stretch_inc = stretch_q + 16'd1;

		if (phase_q == PH_IDLE) begin
			if ((q_tick.action == ACT_START || q_tick.action == ACT_WRITE) &&
			    err_q != ST_OK) begin
				n_phase = PH_IDLE; n_wait = 1'b0; n_delay = '0;
				done = 1'b1; stat = ST_SKIPPED;
			end else if (q_tick.action == ACT_START) begin
				n_sda = 1'b1; n_scl = 1'b1; n_stretch = '0; n_wait = 1'b1;
				n_phase = PH_S_CHECK;
			end else if (q_tick.action == ACT_WRITE) begin
				n_shift = q_tick.data_byte;
				n_bit   = '0;
				do_act  = 1'b1;
				act_ph  = PH_W_BIT;
			end else if (q_tick.action == ACT_STOP) begin
				n_scl = 1'b0; n_sda = 1'b0; n_delay = half_q; n_phase = PH_P_CLK;
			end else if (q_tick.action == ACT_RECOVER) begin
				n_err = ST_OK; n_sda = 1'b1; n_scl = 1'b0; n_pulse = '0;
				n_delay = half_q; n_phase = PH_R_CLK;
			end
		end else if (wait_q) begin
			if (q_tick.scl_sense) begin
				n_wait  = 1'b0;
				n_delay = half_q;
			end else begin
				n_stretch = stretch_inc;
				if (stretch_inc >= timeout_q) begin
					n_wait = 1'b0;
					if (phase_q == PH_P_SDA) begin
						// timeout inside a stop is ignored
						do_act = 1'b1;
						act_ph = PH_P_SDA;
					end else if (phase_q == PH_R_NEXT) begin
						n_err = ST_TIMEOUT;
						n_scl = 1'b0; n_sda = 1'b0; n_delay = half_q; n_phase = PH_P_CLK;
					end else begin
						n_err = ST_TIMEOUT;
						n_phase = PH_IDLE; n_delay = '0;
						done = 1'b1; stat = ST_TIMEOUT;
					end
				end
			end
		end else begin
			if (delay_q != '0) n_delay = delay_dec;
			do_act = (delay_q == '0) || (delay_dec == '0);
		end

		if (do_act) begin
			unique case (act_ph)
				PH_S_CHECK: begin
					if (!q_tick.sda_sense) begin
						n_err = ST_BUSY;
						n_phase = PH_IDLE; n_wait = 1'b0; n_delay = '0;
						done = 1'b1; stat = ST_BUSY;
					end else begin
						n_sda = 1'b0; n_delay = half_q; n_phase = PH_S_LOW;
					end
				end
				PH_S_LOW: begin
					n_scl = 1'b0; n_delay = half_q; n_phase = PH_S_END;
				end
				PH_S_END: begin
					n_phase = PH_IDLE; n_wait = 1'b0; n_delay = '0;
					done = 1'b1; stat = ST_OK;
				end
				PH_W_BIT: begin
					n_sda = n_shift[7]; n_delay = half_q; n_phase = PH_W_CLK;
				end
				PH_W_CLK: begin
					n_scl = 1'b1; n_stretch = '0; n_wait = 1'b1; n_phase = PH_W_LOW;
				end
				PH_W_LOW: begin
					n_scl   = 1'b0;
					n_shift = {n_shift[6:0], 1'b0};
					n_bit   = n_bit + 4'd1;
					n_delay = half_q;
					n_phase = (n_bit < FRAME_N) ? PH_W_BIT : PH_W_ACK_REL;
				end
				PH_W_ACK_REL: begin
					n_sda = 1'b1; n_delay = half_q; n_phase = PH_W_ACK_CLK;
				end
				PH_W_ACK_CLK: begin
					n_scl = 1'b1; n_stretch = '0; n_wait = 1'b1; n_phase = PH_W_ACK_SAMPLE;
				end
				PH_W_ACK_SAMPLE: begin
					if (q_tick.sda_sense) n_err = ST_NACK;
					n_scl = 1'b0; n_delay = half_q; n_phase = PH_W_END;
				end
				PH_W_END: begin
					n_phase = PH_IDLE; n_wait = 1'b0; n_delay = '0;
					done = 1'b1; stat = n_err;
				end
				PH_P_CLK: begin
					n_scl = 1'b1; n_stretch = '0; n_wait = 1'b1; n_phase = PH_P_SDA;
				end
				PH_P_SDA: begin
					n_sda = 1'b1; n_delay = half_q; n_phase = PH_P_END;
				end
				PH_P_END: begin
					code  = n_err;
					n_err = ST_OK;
					n_phase = PH_IDLE; n_wait = 1'b0; n_delay = '0;
					done = 1'b1; stat = code;
				end
				PH_R_CLK: begin
					n_scl = 1'b1; n_stretch = '0; n_wait = 1'b1; n_phase = PH_R_NEXT;
				end
				PH_R_NEXT: begin
					n_pulse = n_pulse + 4'd1;
					if (n_pulse < PULSES) begin
						n_scl = 1'b0; n_delay = half_q; n_phase = PH_R_CLK;
					end else begin
						n_scl = 1'b0; n_sda = 1'b0; n_delay = half_q; n_phase = PH_P_CLK;
					end
				end
				default: n_phase = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= '0;
			shift_q   <= '0;
			delay_q   <= '0;
			stretch_q <= '0;
			pulse_q   <= '0;
			err_q     <= ST_OK;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			wait_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q   <= n_phase;
				bit_q     <= n_bit;
				shift_q   <= n_shift;
				delay_q   <= n_delay;
				stretch_q <= n_stretch;
				pulse_q   <= n_pulse;
				err_q     <= n_err;
				scl_q     <= n_scl;
				sda_q     <= n_sda;
				wait_q    <= n_wait;
			end
			if (step) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {1'b0, stat, done, (n_phase == PH_IDLE), n_sda, n_scl};
		end
	end

endmodule

// ===== rtl/core/i2c_master_write_engine_core.sv =====
// Flow: a tick accepted on s_tready is written into the queue, stepped by the engine
// from the queue head, and its result is registered in the output register on m_tvalid.
// Throughput: one tick per cycle while neither side stalls; the two-entry queue and
// the output register let either side stall without losing a tick.
// Reset (arst_n low, asynchronous): engine idle, both lines released, no sticky error,
// half period 5 ticks, stretch timeout 100 ticks, queue and output register empty.
module i2c_master_write_engine_core #(
	parameter int RECOVERY_PULSES = i2cmw_pkg::RECOVERY_PULSES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [i2cmw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// action[2:0], data_byte[10:3], scl_sense[11], sda_sense[12], zero[15:13]
	input  logic [i2cmw_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// scl_release[0], sda_release[1], ready_res[2], done_res[3], status[6:4], zero[7]
	output logic [i2cmw_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import i2cmw_pkg::*;

	logic  q_valid;
	tick_t q_tick;
	logic  q_pop;

	i2cmw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_tick   (q_tick),
		.q_pop    (q_pop)
	);

	i2cmw_engine #(
		.RECOVERY_PULSES (RECOVERY_PULSES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_tick    (q_tick),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== bench/tb_i2c_master_write_engine_core.sv =====
module tb_i2c_master_write_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          MAX_REPORTS = 20;

	// engine state as predicted, plus the done pulse of the current tick
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bits;
		logic [7:0]  shreg;
		logic [9:0]  delay;
		logic [15:0] stretch;
		logic [3:0]  pulses;
		status_t     err;
		logic        scl;
		logic        sda;
		logic        waiting;
		logic        done;
		status_t     code;
	} eng_t;

	// laid out as on m_tdata[6:0]
	typedef struct packed {
		status_t status;
		logic    done;
		logic    ready;
		logic    sda;
		logic    scl;
	} pins_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// action[2:0], data_byte[10:3], scl_sense[11], sda_sense[12], zero[15:13]
	logic [15:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// scl_release[0], sda_release[1], ready_res[2], done_res[3], status[6:4], zero[7]
	logic [7:0]  m_tdata;

	logic [9:0]  half_ticks = HALF_RESET;
	logic [15:0] tmo_ticks  = STRETCH_RESET;

	eng_t        sched_eng;
	eng_t        pred_eng;
	tick_t       cur_tick;
	tick_t       pending_ticks[$];
	pins_t       expected_pins[$];
	logic [7:0]  want;

	int          idle_pct     = 0;
	int          stall_pct    = 0;
	int          glitch_pct   = 0;
	int          busy_cmd_pct = 0;
	int          errors       = 0;
	int          sched_count  = 0;
	int          ticks_sent   = 0;
	int          n_done       = 0;
	int          n_bad        = 0;
	int          n_settings   = 1;
	int unsigned cycles       = 0;

	i2c_master_write_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic eng_t eng_reset();
		eng_t s;
		s = '0;
		s.phase = PH_IDLE;
		s.err = ST_OK;
		s.code = ST_OK;
		s.scl = 1'b1;
		s.sda = 1'b1;
		return s;
	endfunction

	function automatic void eng_finish(inout eng_t s, input status_t c);
		s.phase = PH_IDLE;
		s.waiting = 1'b0;
		s.delay = '0;
		s.done = 1'b1;
		s.code = c;
	endfunction

	function automatic void eng_fail(inout eng_t s, input status_t c);
		s.err = c;
		eng_finish(s, c);
	endfunction

	function automatic void eng_hold(inout eng_t s, input phase_t nxt);
		s.delay = half_ticks;
		s.phase = nxt;
	endfunction

	function automatic void eng_release_scl(inout eng_t s, input phase_t nxt);
		s.scl = 1'b1;
		s.stretch = '0;
		s.waiting = 1'b1;
		s.phase = nxt;
	endfunction

	function automatic void eng_begin_stop(inout eng_t s);
		s.scl = 1'b0;
		s.sda = 1'b0;
		eng_hold(s, PH_P_CLK);
	endfunction

	function automatic void eng_act(inout eng_t s, input phase_t p, input logic sda_in);
		status_t c;
		case (p)
			PH_S_CHECK: begin
				if (!sda_in) begin
					eng_fail(s, ST_BUSY);
				end else begin
					s.sda = 1'b0;
					eng_hold(s, PH_S_LOW);
				end
			end
			PH_S_LOW: begin
				s.scl = 1'b0;
				eng_hold(s, PH_S_END);
			end
			PH_S_END: eng_finish(s, ST_OK);
			PH_W_BIT: begin
				s.sda = s.shreg[7];
				eng_hold(s, PH_W_CLK);
			end
			PH_W_CLK: eng_release_scl(s, PH_W_LOW);
			PH_W_LOW: begin
				s.scl = 1'b0;
				s.shreg = s.shreg << 1;
				s.bits = s.bits + 4'd1;
				if (s.bits < BITS_PER_FRAME) begin
					eng_hold(s, PH_W_BIT);
				end else begin
					eng_hold(s, PH_W_ACK_REL);
				end
			end
			PH_W_ACK_REL: begin
				s.sda = 1'b1;
				eng_hold(s, PH_W_ACK_CLK);
			end
			PH_W_ACK_CLK: eng_release_scl(s, PH_W_ACK_SAMPLE);
			PH_W_ACK_SAMPLE: begin
				if (sda_in) s.err = ST_NACK;
				s.scl = 1'b0;
				eng_hold(s, PH_W_END);
			end
			PH_W_END: eng_finish(s, s.err);
			PH_P_CLK: eng_release_scl(s, PH_P_SDA);
			PH_P_SDA: begin
				s.sda = 1'b1;
				eng_hold(s, PH_P_END);
			end
			PH_P_END: begin
				c = s.err;
				s.err = ST_OK;
				eng_finish(s, c);
			end
			PH_R_CLK: eng_release_scl(s, PH_R_NEXT);
			PH_R_NEXT: begin
				s.pulses = s.pulses + 4'd1;
				if (s.pulses < RECOVERY_PULSES_DEF) begin
					s.scl = 1'b0;
					eng_hold(s, PH_R_CLK);
				end else begin
					eng_begin_stop(s);
				end
			end
			default: s.phase = PH_IDLE;
		endcase
	endfunction

	// advance the engine by one tick and return the pins it drives afterwards
	function automatic pins_t engine_tick(inout eng_t s, input tick_t t);
		pins_t r;
		logic  run;
		s.done = 1'b0;
		s.code = ST_OK;
		if (s.phase == PH_IDLE) begin
			if ((t.action == ACT_START || t.action == ACT_WRITE) && s.err != ST_OK) begin
				eng_finish(s, ST_SKIPPED);
			end else begin
				case (t.action)
					ACT_START: begin
						s.sda = 1'b1;
						eng_release_scl(s, PH_S_CHECK);
					end
					ACT_WRITE: begin
						s.shreg = t.data_byte;
						s.bits = '0;
						eng_act(s, PH_W_BIT, t.sda_sense);
					end
					ACT_STOP: eng_begin_stop(s);
					ACT_RECOVER: begin
						s.err = ST_OK;
						s.sda = 1'b1;
						s.scl = 1'b0;
						s.pulses = '0;
						eng_hold(s, PH_R_CLK);
					end
					default: ;
				endcase
			end
		end else if (s.waiting) begin
			if (t.scl_sense) begin
				s.waiting = 1'b0;
				s.delay = half_ticks;
			end else begin
				s.stretch = s.stretch + 16'd1;
				if (s.stretch >= tmo_ticks) begin
					s.waiting = 1'b0;
					// a stop carries on regardless; recovery falls through to its stop
					if (s.phase == PH_P_SDA) begin
						eng_act(s, PH_P_SDA, t.sda_sense);
					end else if (s.phase == PH_R_NEXT) begin
						s.err = ST_TIMEOUT;
						eng_begin_stop(s);
					end else begin
						eng_fail(s, ST_TIMEOUT);
					end
				end
			end
		end else begin
			run = 1'b1;
			if (s.delay != 0) begin
				s.delay = s.delay - 10'd1;
				if (s.delay != 0) run = 1'b0;
			end
			if (run) eng_act(s, s.phase, t.sda_sense);
		end
		r.scl = s.scl;
		r.sda = s.sda;
		r.ready = (s.phase == PH_IDLE);
		r.done = s.done;
		r.status = s.code;
		return r;
	endfunction

	function automatic int pick_stretch();
		int lim;
		lim = (tmo_ticks == 0) ? 1 : int'(tmo_ticks);
		if ($urandom_range(99) < 15) return $urandom_range(lim + 2, 1);
		return 0;
	endfunction

	task automatic push_tick(input tick_t t);
		pending_ticks.push_back(t);
		void'(engine_tick(sched_eng, t));
		sched_count++;
	endtask

	// one command, then plain ticks until the engine is back to idle;
	// SCL is sensed low on the first stretch_len ticks that wait on a clock release
	task automatic issue(input action_t a, input logic [7:0] d, input bit bus_free,
			input bit acked, input int stretch_len);
		tick_t t;
		int    left;
		left = stretch_len;
		t.action = a;
		t.data_byte = d;
		t.scl_sense = 1'($urandom_range(1));
		t.sda_sense = 1'($urandom_range(1));
		push_tick(t);
		while (sched_eng.phase != PH_IDLE) begin
			t.action = ACT_NONE;
			if ($urandom_range(99) < busy_cmd_pct) t.action = action_t'(3'($urandom_range(7, 1)));
			t.data_byte = 8'($urandom);
			if (sched_eng.waiting && left > 0) begin
				t.scl_sense = 1'b0;
				left--;
			end else if (sched_eng.waiting) begin
				t.scl_sense = ($urandom_range(99) >= glitch_pct);
			end else begin
				t.scl_sense = 1'($urandom_range(1));
			end
			case (sched_eng.phase)
				PH_S_CHECK:      t.sda_sense = bus_free;
				PH_W_ACK_SAMPLE: t.sda_sense = !acked;
				default:         t.sda_sense = 1'($urandom_range(1));
			endcase
			push_tick(t);
		end
	endtask

	task automatic random_ticks(input int n);
		int stop_at;
		int k;
		stop_at = sched_count + n;
		while (sched_count < stop_at) begin
			if ($urandom_range(99) < 70) begin
				issue(ACT_START, 8'($urandom), $urandom_range(99) < 90, 1'b1, pick_stretch());
				k = $urandom_range(3, 1);
				repeat (k) issue(ACT_WRITE, 8'($urandom), 1'b1, $urandom_range(99) < 85,
						pick_stretch());
				issue(ACT_STOP, 8'($urandom), 1'b1, 1'b1, pick_stretch());
			end else begin
				case ($urandom_range(5))
					0: issue(ACT_RECOVER, 8'($urandom), 1'b1, 1'b1, pick_stretch());
					1: issue(ACT_WRITE, 8'($urandom), 1'b1, 1'($urandom_range(1)), pick_stretch());
					2: issue(ACT_STOP, 8'($urandom), 1'b1, 1'b1, pick_stretch());
					3: issue(ACT_START, 8'($urandom), 1'($urandom_range(1)), 1'b1, pick_stretch());
					4: issue(action_t'(3'($urandom_range(7, 5))), 8'($urandom), 1'b1, 1'b1, 0);
					default: issue(ACT_NONE, 8'($urandom), 1'b1, 1'b1, 0);
				endcase
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_ticks.size() != 0 || s_tvalid || expected_pins.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [9:0] h, input logic [15:0] t);
		logic [5:0] junk;
		junk = 6'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= {junk, h};
		@(posedge clk);
		cfg_index <= REG_STRETCH_TO;
		cfg_data <= t;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		half_ticks = h;
		tmo_ticks = t;
		n_settings++;
	endtask

	// sender: one transaction per accepted tick
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_pins.push_back(engine_tick(pred_eng, cur_tick));
				ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_tick = pending_ticks.pop_front();
					s_tdata <= {3'b000, cur_tick.sda_sense, cur_tick.scl_sense,
							cur_tick.data_byte, cur_tick.action};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				if (expected_pins.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected transaction, got %h", $time, m_tdata);
				end else begin
					want = {1'b0, expected_pins.pop_front()};
					if (want[3]) n_done++;
					if (want[3] && want[6:4] != ST_OK) n_bad++;
					if (m_tdata !== want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: expected pad_status_done_ready_sda_scl=%b_%b_%b_%b_%b_%b, got %b_%b_%b_%b_%b_%b",
									$time, want[7], want[6:4], want[3], want[2], want[1],
									want[0], m_tdata[7], m_tdata[6:4], m_tdata[3],
									m_tdata[2], m_tdata[1], m_tdata[0]);
					end
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		sched_eng = eng_reset();
		pred_eng = eng_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: 5 tick half period, timeout of 100
		issue(ACT_START, 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_STOP, 8'h00, 1'b1, 1'b1, 100);
		issue(ACT_START, 8'h00, 1'b0, 1'b1, 0);
		issue(ACT_WRITE, 8'h5A, 1'b1, 1'b1, 0);
		issue(action_t'(3'd5), 8'h00, 1'b1, 1'b1, 0);
		issue(action_t'(3'd6), 8'hFF, 1'b1, 1'b1, 0);
		issue(action_t'(3'd7), 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_NONE, 8'hFF, 1'b1, 1'b1, 0);
		issue(ACT_STOP, 8'h00, 1'b1, 1'b1, 0);
		drain();

		// directed, short settings: stretches under, at and past the timeout
		set_config(10'd1, 16'd3);
		issue(ACT_START, 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_WRITE, 8'hA5, 1'b1, 1'b1, 2);
		issue(ACT_WRITE, 8'h00, 1'b1, 1'b0, 0);
		issue(ACT_WRITE, 8'h5A, 1'b1, 1'b1, 0);
		issue(ACT_START, 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_STOP, 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_START, 8'h00, 1'b1, 1'b1, 0);
		issue(ACT_WRITE, 8'h3C, 1'b1, 1'b1, 3);
		issue(ACT_STOP, 8'h00, 1'b1, 1'b1, 5);
		issue(ACT_START, 8'h00, 1'b0, 1'b1, 0);
		issue(ACT_RECOVER, 8'h00, 1'b1, 1'b1, 2);
		issue(ACT_RECOVER, 8'h00, 1'b1, 1'b1, 3);
		// commands landing while busy must be dropped
		busy_cmd_pct = 50;
		issue(ACT_WRITE, 8'h81, 1'b1, 1'b1, 0);
		busy_cmd_pct = 0;
		drain();

		glitch_pct = 3;
		busy_cmd_pct = 3;

		idle_pct = 78;
		random_ticks(20);
		// hold the sender back until the pipeline has emptied
		drain();
		random_ticks(15);
		drain();

		set_config(10'd2, 16'd7);
		idle_pct = 0;
		stall_pct = 78;
		random_ticks(30);
		drain();

		set_config(10'd0, 16'd0);
		idle_pct = 30;
		stall_pct = 30;
		random_ticks(30);
		drain();

		set_config(10'd2, 16'd1);
		idle_pct = 0;
		stall_pct = 0;
		random_ticks(20);
		drain();
		repeat (10) @(posedge clk);

		$display("%0d ticks checked over %0d register settings", ticks_sent, n_settings);
		$display("%0d commands finished, %0d with an error or skipped status", n_done, n_bad);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
